// ===== src/dgt_pkg.sv =====
package dgt_pkg;

    typedef enum logic [1:0] {
        REQ_INTEREST = 2'd0,
        REQ_DATA     = 2'd1,
        REQ_QUERY    = 2'd2,
        REQ_EXPIRE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_NBR    = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_RD    = 6'b000100,
        S_WAIT  = 6'b001000,
        S_MOD   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    localparam logic [3:0] LEVEL_MAX    = 4'd15;
    localparam logic [7:0] REPEAT_MAX   = 8'd255;
    localparam logic [3:0] LEVEL_NEW    = 4'd3;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    // Mask of neighbors whose four-bit level is nonzero.
    function automatic logic [31:0] nz_mask(input logic [127:0] lv);
        logic [31:0] m;
        m = '0;
        for (int n = 0; n < 32; n++)
        begin
            m[n] = |lv[n*4 +: 4];
        end
        return m;
    endfunction

endpackage

// ===== src/dgt_ram.sv =====
module dgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/diffusion_gradient_table_unit.sv =====
// Gradient table for directed diffusion, keyed by a 128-bit interest id.
// One request is taken when start is high and busy is low; busy then stays
// high until the single result beat appears on status and neighbor_mask with
// done high for exactly one cycle. The receiver cannot stall that beat, so it
// must sample it when done is high. The block walks every slot once through a
// single id/timestamp memory read port, one slot per cycle, to find a match,
// the lowest free slot, or idle slots to expire, with a pipelined read. A
// request that hits an existing slot (interest or data hit, query hit) then
// re-reads that slot through S_RD, S_WAIT and S_MOD; an interest or data hit
// does one read-modify-write of its levels, while a query hit only reads them.
// Allocation, a full table, a missing id, a missing neighbor on data, and
// expire finish right after the scan, going from S_RD straight to S_DONE.
// Busy drops in the cycle after the result beat. Entries are fully written
// when allocated, so the slot memories need no clearing pass after reset.
module diffusion_gradient_table_unit #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic [1:0]  req_type,
    input  logic [63:0] id_high,
    input  logic [63:0] id_low,
    input  logic [31:0] sender_count,
    input  logic        neighbor_present,
    input  logic [4:0]  neighbor_index,
    input  logic [31:0] time_now,
    output logic [1:0]  status,
    output logic [31:0] neighbor_mask
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    // Per-slot key record: id, last sender count, refresh time.
    localparam int KW = 128 + 32 + 32;
    // Per-slot level record: interest, data levels and repeat count.
    localparam int LW = 128 + 128 + 8;

    dgt_pkg::state_t state_reg, state_next;

    logic [31:0]  max_idle_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic          found_reg, found_next;
    logic [AW-1:0] free_reg, free_next;
    logic          has_free_reg, has_free_next;
    logic          vld_d_reg;
    logic [AW-1:0] addr_d_reg;
    logic          rd_active_reg;

    // Captured request.
    logic [1:0]   req_reg;
    logic [63:0]  hi_reg, lo_reg;
    logic [31:0]  cnt_reg, now_reg;
    logic         nbr_reg;
    logic [4:0]   ni_reg;

    logic [1:0]   status_reg, status_next;
    logic [31:0]  mask_reg, mask_next;
    logic         done_reg;

    // Key memory.
    logic          k_we;
    logic [AW-1:0] k_waddr, k_raddr;
    logic [KW-1:0] k_wdata, k_rdata;
    // Level memory.
    logic          l_we;
    logic [AW-1:0] l_raddr;
    logic [LW-1:0] l_wdata, l_rdata;

    dgt_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    dgt_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_lvl (
        .clk(clk), .we(l_we), .waddr(k_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    // Fields of the key record read back during the scan.
    logic [127:0] rd_id;
    logic [31:0]  rd_cnt, rd_time, idle;
    assign rd_id   = k_rdata[KW-1 -: 128];
    assign rd_cnt  = k_rdata[63:32];
    assign rd_time = k_rdata[31:0];
    assign idle    = now_reg - rd_time;

    // Level record fields for the read-modify-write.
    logic [127:0] il, dl;
    logic [7:0]   rep;
    assign il  = l_rdata[LW-1 -: 128];
    assign dl  = l_rdata[135:8];
    assign rep = l_rdata[7:0];

    logic [6:0]  nsh;
    logic [3:0]  lv_i, lv_d;
    logic [4:0]  sum_i;
    logic [3:0]  new_i, new_d;
    logic [7:0]  rep_new;
    logic        cnt_new;
    logic [31:0] nbit, dmask;
    logic [127:0] il_new, dl_new;

    assign nsh  = {ni_reg, 2'b00};
    assign lv_i = il[nsh +: 4];
    assign lv_d = dl[nsh +: 4];
    assign nbit = nbr_reg ? (32'd1 << ni_reg) : 32'd0;
    assign dmask = dgt_pkg::nz_mask(dl);

    always_comb
    begin
        // The hit slot's key was re-read in S_RD, so its sender count is at hand.
        cnt_new = (rd_cnt != cnt_reg);
        rep_new = rep;
        sum_i   = {1'b0, lv_i};
        if (cnt_new)
        begin
            rep_new = 8'd0;
            sum_i   = {1'b0, lv_i} + 5'd3;
        end
        else
        begin
            if (rep != dgt_pkg::REPEAT_MAX)
            begin
                rep_new = rep + 8'd1;
            end
            if (rep_new == 8'd1)
            begin
                sum_i = {1'b0, lv_i} + 5'd2;
            end
            else if (rep_new == 8'd2)
            begin
                sum_i = {1'b0, lv_i} + 5'd1;
            end
        end
        new_i = sum_i[4] ? dgt_pkg::LEVEL_MAX : sum_i[3:0];
        new_d = (lv_d == dgt_pkg::LEVEL_MAX) ? lv_d : lv_d + 4'd1;
        il_new = il;
        if (nbr_reg)
        begin
            il_new[nsh +: 4] = new_i;
        end
        dl_new = dl;
        dl_new[nsh +: 4] = new_d;
    end

    assign k_raddr = idx_reg[AW-1:0];
    assign l_raddr = hit_reg;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        free_next     = free_reg;
        has_free_next = has_free_reg;
        status_next   = status_reg;
        mask_next     = mask_reg;
        k_we    = 1'b0;
        l_we    = 1'b0;
        k_waddr = hit_reg;
        k_wdata = {hi_reg, lo_reg, cnt_reg, now_reg};
        l_wdata = {il, dl, rep};

        case (state_reg)
            dgt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    idx_next      = '0;
                    found_next    = 1'b0;
                    has_free_next = 1'b0;
                    status_next   = dgt_pkg::ST_OK;
                    mask_next     = '0;
                    state_next    = dgt_pkg::S_SCAN;
                end
            end
            dgt_pkg::S_SCAN:
            begin
                // Read address idx_reg is issued; data of the previous slot returns.
                if (rd_active_reg && vld_d_reg)
                begin
                    if (req_reg == dgt_pkg::REQ_EXPIRE)
                    begin
                        if (idle > max_idle_reg)
                        begin
                            valid_next[addr_d_reg] = 1'b0;
                        end
                    end
                    else if (!found_reg && rd_id == {hi_reg, lo_reg})
                    begin
                        found_next = 1'b1;
                        hit_next   = addr_d_reg;
                    end
                end
                if (rd_active_reg && !vld_d_reg && !has_free_reg)
                begin
                    has_free_next = 1'b1;
                    free_next     = addr_d_reg;
                end
                if (idx_reg == CW'(ENTRIES))
                begin
                    state_next = dgt_pkg::S_RD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            dgt_pkg::S_RD:
            begin
                // Re-read the hit slot's key so its sender count is at hand.
                state_next = dgt_pkg::S_WAIT;
                case (req_reg)
                    dgt_pkg::REQ_INTEREST:
                    begin
                        if (!found_reg)
                        begin
                            if (has_free_reg)
                            begin
                                valid_next[free_reg] = 1'b1;
                                k_we    = 1'b1;
                                l_we    = 1'b1;
                                k_waddr = free_reg;
                                l_wdata = '0;
                                if (nbr_reg)
                                begin
                                    l_wdata[LW-1 -: 128] =
                                        128'(dgt_pkg::LEVEL_NEW) << nsh;
                                end
                                mask_next  = dgt_pkg::ALL_ONES & ~nbit;
                            end
                            else
                            begin
                                status_next = dgt_pkg::ST_FULL;
                            end
                            state_next = dgt_pkg::S_DONE;
                        end
                    end
                    dgt_pkg::REQ_DATA:
                    begin
                        if (!nbr_reg)
                        begin
                            status_next = dgt_pkg::ST_NO_NBR;
                            state_next  = dgt_pkg::S_DONE;
                        end
                        else if (!found_reg)
                        begin
                            status_next = dgt_pkg::ST_NOT_FOUND;
                            state_next  = dgt_pkg::S_DONE;
                        end
                    end
                    dgt_pkg::REQ_QUERY:
                    begin
                        if (!found_reg)
                        begin
                            status_next = dgt_pkg::ST_NOT_FOUND;
                            state_next  = dgt_pkg::S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = dgt_pkg::S_DONE;
                    end
                endcase
            end
            dgt_pkg::S_WAIT:
            begin
                state_next = dgt_pkg::S_MOD;
            end
            dgt_pkg::S_MOD:
            begin
                state_next = dgt_pkg::S_DONE;
                case (req_reg)
                    dgt_pkg::REQ_INTEREST:
                    begin
                        l_we    = 1'b1;
                        l_wdata = {il_new, dl, rep_new};
                        if (cnt_new)
                        begin
                            k_we    = 1'b1;
                            mask_next = (dmask == 32'd0) ?
                                        (dgt_pkg::ALL_ONES & ~nbit) : dmask;
                        end
                    end
                    dgt_pkg::REQ_DATA:
                    begin
                        l_we    = 1'b1;
                        l_wdata = {il, dl_new, rep};
                    end
                    default:
                    begin
                        mask_next = dgt_pkg::nz_mask(il);
                    end
                endcase
            end
            dgt_pkg::S_DONE:
            begin
                state_next = dgt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dgt_pkg::S_IDLE;
            end
        endcase
    end

    // During S_WAIT/S_MOD the key port must present the hit slot.
    logic [AW-1:0] scan_addr;
    assign scan_addr = idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dgt_pkg::S_IDLE;
            max_idle_reg  <= 32'd600;
            valid_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            has_free_reg  <= 1'b0;
            rd_active_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            idx_reg       <= (state_next == dgt_pkg::S_RD) ? CW'(hit_next) : idx_next;
            found_reg     <= found_next;
            has_free_reg  <= has_free_next;
            rd_active_reg <= (state_reg == dgt_pkg::S_SCAN) &&
                             (idx_reg != CW'(ENTRIES));
            done_reg      <= (state_next == dgt_pkg::S_DONE);
            if (cfg_we)
            begin
                max_idle_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        free_reg   <= free_next;
        status_reg <= status_next;
        mask_reg   <= mask_next;
        addr_d_reg <= scan_addr;
        vld_d_reg  <= valid_reg[scan_addr];
        if (state_reg == dgt_pkg::S_IDLE && start)
        begin
            req_reg <= req_type;
            hi_reg  <= id_high;
            lo_reg  <= id_low;
            cnt_reg <= sender_count;
            now_reg <= time_now;
            nbr_reg <= neighbor_present;
            ni_reg  <= neighbor_index;
        end
    end

    assign busy          = (state_reg != dgt_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign neighbor_mask = mask_reg;

endmodule
